FILE: rtl/core/slb_pkg.sv
// Package for the serial LCD bridge: operation, result and register codes,
// timer sizing and the result queue types. It depends on nothing else.
package slb_pkg;

    localparam int TIMER_BITS = 16;
    localparam int GAP_BITS   = 16;
    localparam int CMP_BITS   = (TIMER_BITS > GAP_BITS) ? TIMER_BITS : GAP_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_ADDR_BITS = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_ABITS = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] ESC_COMMAND   = 8'hFE;
    localparam logic [7:0] ESC_BACKLIGHT = 8'hFD;

    localparam logic [15:0] DATA_GAP_RESET   = 16'd40;
    localparam logic [15:0] SLOW_GAP_RESET   = 16'd2000;
    localparam logic [8:0]  SLOW_BELOW_RESET = 9'd4;
    localparam logic [7:0]  IDLE_KEY_RESET   = 8'd0;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_TICK = 2'd1,
        OP_KEY  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        KIND_DATA      = 3'd0,
        KIND_COMMAND   = 3'd1,
        KIND_BACKLIGHT = 3'd2,
        KIND_TX        = 3'd3,
        KIND_REJECT    = 3'd4
    } t_kind;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_DATA_GAP   = 2'd0,
        CFG_SLOW_GAP   = 2'd1,
        CFG_SLOW_BELOW = 2'd2,
        CFG_IDLE_KEY   = 2'd3
    } t_cfg_addr;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] payload;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

FILE: rtl/core/slb_front.sv
// Front end of the serial LCD bridge: parser, microsecond timer, pending slot,
// keypad change detector and configuration registers. Uses slb_pkg.
module slb_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic [1:0]                           i_op,
    input  logic [7:0]                           i_value,
    input  logic                                 i_cfg_we,
    input  logic [slb_pkg::CFG_ADDR_BITS-1:0]    i_cfg_addr,
    input  logic [slb_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    output slb_pkg::t_push                       o_push
);

    typedef enum logic [2:0] {
        MODE_PLAIN     = 3'b001,
        MODE_COMMAND   = 3'b010,
        MODE_BACKLIGHT = 3'b100
    } t_mode;

    t_mode                           r_mode, n_mode;
    logic [slb_pkg::TIMER_BITS-1:0]  r_elapsed, n_elapsed;
    logic                            r_pend_valid, n_pend_valid;
    logic                            r_pend_cmd, n_pend_cmd;
    logic [7:0]                      r_pend_byte, n_pend_byte;
    logic [7:0]                      r_prev_key, n_prev_key;
    logic [15:0]                     r_data_gap;
    logic [15:0]                     r_slow_gap;
    logic [8:0]                      r_slow_below;
    logic [7:0]                      r_idle_key;

    logic [slb_pkg::TIMER_BITS-1:0]  elapsed_inc;
    logic                            byte_gap_ok;
    logic                            tick_gap_ok;
    logic                            lcd_cmd;
    slb_pkg::t_push                  push;

    function automatic logic gap_met(
        input logic                           is_cmd,
        input logic [7:0]                     b,
        input logic [slb_pkg::TIMER_BITS-1:0] elapsed,
        input logic [15:0]                    data_gap,
        input logic [15:0]                    slow_gap,
        input logic [8:0]                     slow_below
    );
        logic [15:0] gap;
        gap = (is_cmd && ({1'b0, b} < slow_below)) ? slow_gap : data_gap;
        return (elapsed == slb_pkg::TIMER_MAX) ||
               (slb_pkg::CMP_BITS'(elapsed) >= slb_pkg::CMP_BITS'(gap));
    endfunction

    assign elapsed_inc = (r_elapsed == slb_pkg::TIMER_MAX) ? r_elapsed :
                         r_elapsed + slb_pkg::TIMER_BITS'(1);
    assign lcd_cmd     = (r_mode == MODE_COMMAND);
    assign byte_gap_ok = gap_met(lcd_cmd, i_value, r_elapsed,
                                 r_data_gap, r_slow_gap, r_slow_below);
    assign tick_gap_ok = gap_met(r_pend_cmd, r_pend_byte, elapsed_inc,
                                 r_data_gap, r_slow_gap, r_slow_below);

    always_comb begin
        logic is_lcd;
        n_mode       = r_mode;
        n_elapsed    = r_elapsed;
        n_pend_valid = r_pend_valid;
        n_pend_cmd   = r_pend_cmd;
        n_pend_byte  = r_pend_byte;
        n_prev_key   = r_prev_key;
        push         = '0;
        is_lcd       = 1'b0;
        unique case (slb_pkg::t_op'(i_op))
            slb_pkg::OP_BYTE: begin
                n_mode = MODE_PLAIN;
                unique case (r_mode)
                    MODE_COMMAND: begin
                        is_lcd = 1'b1;
                    end
                    MODE_BACKLIGHT: begin
                        push.count  = 2'd1;
                        push.first  = '{slb_pkg::KIND_BACKLIGHT, i_value, 1'b1};
                    end
                    default: begin
                        if (i_value == slb_pkg::ESC_COMMAND) begin
                            n_mode = MODE_COMMAND;
                        end else if (i_value == slb_pkg::ESC_BACKLIGHT) begin
                            n_mode = MODE_BACKLIGHT;
                        end else begin
                            is_lcd = 1'b1;
                        end
                    end
                endcase
                if (is_lcd) begin
                    push.count = 2'd1;
                    if (r_pend_valid) begin
                        push.first = '{slb_pkg::KIND_REJECT, i_value, 1'b1};
                    end else if (byte_gap_ok) begin
                        push.first = '{lcd_cmd ? slb_pkg::KIND_COMMAND : slb_pkg::KIND_DATA,
                                       i_value, 1'b1};
                        n_elapsed  = '0;
                    end else begin
                        push.count   = 2'd0;
                        n_pend_valid = 1'b1;
                        n_pend_cmd   = lcd_cmd;
                        n_pend_byte  = i_value;
                    end
                end
            end
            slb_pkg::OP_TICK: begin
                n_elapsed = elapsed_inc;
                if (r_pend_valid && tick_gap_ok) begin
                    push.count   = 2'd1;
                    push.first   = '{r_pend_cmd ? slb_pkg::KIND_COMMAND : slb_pkg::KIND_DATA,
                                     r_pend_byte, 1'b1};
                    n_pend_valid = 1'b0;
                    n_elapsed    = '0;
                end
            end
            slb_pkg::OP_KEY: begin
                if (i_value != r_prev_key) begin
                    n_prev_key = i_value;
                    if (i_value != r_idle_key) begin
                        push.count  = 2'd2;
                        push.first  = '{slb_pkg::KIND_TX, slb_pkg::ESC_COMMAND, 1'b0};
                        push.second = '{slb_pkg::KIND_TX, i_value, 1'b1};
                    end
                end
            end
            default: begin
            end
        endcase
        if (!i_accept) begin
            push.count = 2'd0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_PLAIN;
            r_elapsed    <= '0;
            r_pend_valid <= 1'b0;
            r_pend_cmd   <= 1'b0;
            r_pend_byte  <= '0;
            r_prev_key   <= slb_pkg::IDLE_KEY_RESET;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_elapsed    <= n_elapsed;
            r_pend_valid <= n_pend_valid;
            r_pend_cmd   <= n_pend_cmd;
            r_pend_byte  <= n_pend_byte;
            r_prev_key   <= n_prev_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_gap   <= slb_pkg::DATA_GAP_RESET;
            r_slow_gap   <= slb_pkg::SLOW_GAP_RESET;
            r_slow_below <= slb_pkg::SLOW_BELOW_RESET;
            r_idle_key   <= slb_pkg::IDLE_KEY_RESET;
        end else if (i_cfg_we) begin
            unique case (slb_pkg::t_cfg_addr'(i_cfg_addr))
                slb_pkg::CFG_DATA_GAP:   r_data_gap   <= i_cfg_data[15:0];
                slb_pkg::CFG_SLOW_GAP:   r_slow_gap   <= i_cfg_data[15:0];
                slb_pkg::CFG_SLOW_BELOW: r_slow_below <= i_cfg_data[8:0];
                slb_pkg::CFG_IDLE_KEY:   r_idle_key   <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/slb_queue.sv
// Result queue of the serial LCD bridge: takes up to two results per cycle
// from the front end and hands them out one per transaction. Uses slb_pkg.
module slb_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  slb_pkg::t_push   i_push,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output slb_pkg::t_result o_head
);

    localparam int DEPTH = slb_pkg::QUEUE_DEPTH;
    localparam int ABITS = slb_pkg::QUEUE_ABITS;

    slb_pkg::t_result r_mem [DEPTH];
    logic [ABITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [ABITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [ABITS:0]   r_count, n_count;
    logic             pop_ok;
    logic [ABITS-1:0] wr_next;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count > (ABITS+1)'(DEPTH - 2));
    assign o_head  = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop && !o_empty;
    assign wr_next = r_wr_ptr + ABITS'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + ABITS'(i_push.count);
        n_rd_ptr = pop_ok ? r_rd_ptr + ABITS'(1) : r_rd_ptr;
        n_count  = r_count + (ABITS+1)'(i_push.count) - (ABITS+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (ABITS+1)'(DEPTH))
        else $error("Result queue count exceeds its depth.");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count != 2'd0) |-> (r_count <= (ABITS+1)'(DEPTH - 2)))
        else $error("Results written while the queue lacks room for two.");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop_ok && r_count == (ABITS+1)'(1) && i_push.count == 2'd0) |=> o_empty)
        else $error("Queue not empty after its last result was taken.");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.count == 2'd2) |-> (!i_push.first.last && i_push.second.last))
        else $error("A result pair does not end on its second entry.");

endmodule

FILE: rtl/core/serial_lcd_bridge_with_keypad.sv
// Top level of the serial LCD bridge with keypad: joins the front end and the
// result queue. Uses slb_pkg, slb_front and slb_queue.
//
// The block takes one transaction per clock cycle while full is low: a
// received serial byte, a microsecond tick or a keypad sample, each decided by
// the front end, whose state (parse mode, elapsed-time counter, pending slot
// and last key) is updated at the edge that accepts the transaction. Each
// transaction yields zero, one or two results, which appear on the result
// ports from the next cycle on, oldest first, through a four-entry queue that
// drains one result per cycle while pop is high. full is raised while fewer
// than two queue entries are free, so with pop held high the block sustains
// one transaction per cycle except for key changes, which yield two results.
// Configuration registers are written through i_cfg_we, i_cfg_addr and
// i_cfg_data at any edge; no clearing pass follows reset.
module serial_lcd_bridge_with_keypad (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        i_op,
    input  logic [7:0]                        i_value,
    output logic                              empty,
    input  logic                              pop,
    output logic [2:0]                        o_kind,
    output logic [7:0]                        o_payload,
    output logic                              o_last,
    input  logic                              i_cfg_we,
    input  logic [slb_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [slb_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    logic             accept;
    slb_pkg::t_push   front_push;
    slb_pkg::t_result head;

    assign accept = push && !full;

    slb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_op       (i_op),
        .i_value    (i_value),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_push     (front_push)
    );

    slb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    assign o_kind    = head.kind;
    assign o_payload = head.payload;
    assign o_last    = head.last;

endmodule

FILE: tb/tb_serial_lcd_bridge_with_keypad.sv
`timescale 1ns / 1ps
// Self-checking testbench for serial_lcd_bridge_with_keypad: a scoreboard class predicts each
// result from the accepted transactions, and plain tasks drive the queue-style ports.
// Depends on slb_pkg and the RTL of the bridge.

class bridge_scoreboard;
    typedef enum logic [1:0] {
        PARSE_PLAIN     = 2'd0,
        PARSE_COMMAND   = 2'd1,
        PARSE_BACKLIGHT = 2'd2
    } t_parse;

    logic [15:0] data_gap;
    logic [15:0] slow_gap;
    logic [8:0]  slow_below;
    logic [7:0]  idle_key;

    t_parse      parse_mode;
    logic [15:0] elapsed;
    bit          slot_full;
    bit          slot_cmd;
    logic [7:0]  slot_byte;
    logic [7:0]  last_key;

    slb_pkg::t_result lcd_results[$];
    int errors;

    function new();
        data_gap   = slb_pkg::DATA_GAP_RESET;
        slow_gap   = slb_pkg::SLOW_GAP_RESET;
        slow_below = slb_pkg::SLOW_BELOW_RESET;
        idle_key   = slb_pkg::IDLE_KEY_RESET;
        parse_mode = PARSE_PLAIN;
        elapsed    = '0;
        slot_full  = 1'b0;
        slot_cmd   = 1'b0;
        slot_byte  = '0;
        last_key   = slb_pkg::IDLE_KEY_RESET;
        errors     = 0;
    endfunction

    function void write_register(logic [1:0] addr, logic [15:0] data);
        case (addr)
            slb_pkg::CFG_DATA_GAP:   data_gap = data;
            slb_pkg::CFG_SLOW_GAP:   slow_gap = data;
            slb_pkg::CFG_SLOW_BELOW: slow_below = data[8:0];
            slb_pkg::CFG_IDLE_KEY:   idle_key = data[7:0];
            default: ;
        endcase
    endfunction

    function bit gap_met(bit is_cmd, logic [7:0] b);
        logic [15:0] gap;
        gap = (is_cmd && ({1'b0, b} < slow_below)) ? slow_gap : data_gap;
        return (elapsed == slb_pkg::TIMER_MAX) || (elapsed >= gap);
    endfunction

    function void add_result(slb_pkg::t_kind kind, logic [7:0] payload, logic last);
        slb_pkg::t_result r;
        r.kind    = kind;
        r.payload = payload;
        r.last    = last;
        lcd_results.push_back(r);
    endfunction

    function void add_transfer(bit is_cmd, logic [7:0] b);
        if (is_cmd) begin
            add_result(slb_pkg::KIND_COMMAND, b, 1'b1);
        end else begin
            add_result(slb_pkg::KIND_DATA, b, 1'b1);
        end
        elapsed = '0;
    endfunction

    function void lcd_request(bit is_cmd, logic [7:0] b);
        if (slot_full) begin
            add_result(slb_pkg::KIND_REJECT, b, 1'b1);
        end else if (gap_met(is_cmd, b)) begin
            add_transfer(is_cmd, b);
        end else begin
            slot_full = 1'b1;
            slot_cmd  = is_cmd;
            slot_byte = b;
        end
    endfunction

    function void accept_event(logic [1:0] op, logic [7:0] v);
        t_parse mode;
        case (op)
            slb_pkg::OP_BYTE: begin
                mode = parse_mode;
                parse_mode = PARSE_PLAIN;
                if (mode == PARSE_COMMAND) begin
                    lcd_request(1'b1, v);
                end else if (mode == PARSE_BACKLIGHT) begin
                    add_result(slb_pkg::KIND_BACKLIGHT, v, 1'b1);
                end else if (v == slb_pkg::ESC_COMMAND) begin
                    parse_mode = PARSE_COMMAND;
                end else if (v == slb_pkg::ESC_BACKLIGHT) begin
                    parse_mode = PARSE_BACKLIGHT;
                end else begin
                    lcd_request(1'b0, v);
                end
            end
            slb_pkg::OP_TICK: begin
                if (elapsed != slb_pkg::TIMER_MAX) elapsed = elapsed + 16'd1;
                if (slot_full && gap_met(slot_cmd, slot_byte)) begin
                    slot_full = 1'b0;
                    add_transfer(slot_cmd, slot_byte);
                end
            end
            slb_pkg::OP_KEY: begin
                if (v != last_key) begin
                    last_key = v;
                    if (v != idle_key) begin
                        add_result(slb_pkg::KIND_TX, slb_pkg::ESC_COMMAND, 1'b0);
                        add_result(slb_pkg::KIND_TX, v, 1'b1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function void check_output(logic [2:0] kind, logic [7:0] payload, logic last);
        slb_pkg::t_result want;
        if (lcd_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d payload %02h last %0d",
                     $time, kind, payload, last);
            errors++;
            return;
        end
        want = lcd_results.pop_front();
        if (kind !== want.kind) begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, kind);
            errors++;
        end
        if (payload !== want.payload) begin
            $display("%0t: payload expected %02h actual %02h", $time, want.payload, payload);
            errors++;
        end
        if (last !== want.last) begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, last);
            errors++;
        end
    endfunction
endclass

module tb_serial_lcd_bridge_with_keypad;
    import slb_pkg::*;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic [1:0]               i_op = OP_BYTE;
    logic [7:0]               i_value = 8'h00;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [2:0]               o_kind;
    logic [7:0]               o_payload;
    logic                     o_last;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] i_cfg_addr = CFG_DATA_GAP;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;
    bridge_scoreboard sb;

    serial_lcd_bridge_with_keypad dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_register(i_cfg_addr, i_cfg_data);
            if (push && !full) sb.accept_event(i_op, i_value);
            if (pop && !empty) sb.check_output(o_kind, o_payload, o_last);
        end
    end

    initial begin : result_drain
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = 300;
            end
            if (hold == 0 && idle_on && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 4);
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #24000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] v);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_op <= op;
        i_value <= v;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic wait_drained(input int settle);
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.lcd_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [15:0] dgap, input logic [15:0] sgap,
                               input logic [8:0] below, input logic [7:0] idle);
        t_cfg_addr   regs [4] = '{CFG_DATA_GAP, CFG_SLOW_GAP, CFG_SLOW_BELOW, CFG_IDLE_KEY};
        logic [15:0] vals [4];
        vals[0] = dgap;
        vals[1] = sgap;
        vals[2] = {7'd0, below};
        vals[3] = {8'd0, idle};
        wait_drained(4);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_addr <= regs[i];
            i_cfg_data <= vals[i];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ((b == ESC_COMMAND || b == ESC_BACKLIGHT) && $urandom_range(0, 9) != 0)
            b = 8'($urandom_range(0, 252));
        return b;
    endfunction

    task automatic random_items(input int count);
        int done;
        int pick;
        logic [7:0] key;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_item(OP_TICK, 8'($urandom_range(0, 255)));
            end else if (pick < 55) begin
                send_item(OP_BYTE, plain_byte());
            end else if (pick < 67) begin
                send_item(OP_BYTE, ESC_COMMAND);
                if ($urandom_range(0, 1) == 0) begin
                    send_item(OP_BYTE, 8'($urandom_range(0, 9)));
                end else begin
                    send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                end
                done++;
            end else if (pick < 75) begin
                send_item(OP_BYTE, ESC_BACKLIGHT);
                send_item(OP_BYTE, 8'($urandom_range(0, 255)));
                done++;
            end else if (pick < 88) begin
                case ($urandom_range(0, 3))
                    0: key = sb.idle_key;
                    1: key = sb.last_key;
                    2: key = 8'($urandom_range(0, 3));
                    default: key = 8'($urandom_range(0, 255));
                endcase
                send_item(OP_KEY, key);
            end else if (pick < 93) begin
                send_item(OP_NONE, 8'($urandom_range(0, 255)));
                done--;
            end else begin
                send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            done++;
        end
    endtask

    initial begin : stimulus
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset gaps: the first data write waits in the slot and later writes are rejected,
        // while backlight levels and key codes go out regardless.
        send_item(OP_BYTE, ESC_BACKLIGHT);
        send_item(OP_BYTE, 8'h80);
        send_item(OP_BYTE, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_BYTE, ESC_COMMAND);
        send_item(OP_BYTE, 8'h01);
        send_item(OP_BYTE, ESC_BACKLIGHT);
        send_item(OP_BYTE, 8'h7F);
        send_item(OP_NONE, 8'hFF);
        send_item(OP_KEY, 8'hFF);
        send_item(OP_KEY, 8'hFF);
        send_item(OP_KEY, 8'h00);
        send_item(OP_KEY, 8'h5A);

        reconfigure(16'd2, 16'd5, 9'd4, 8'h00);
        repeat (2) send_item(OP_TICK, 8'hFF);
        send_item(OP_BYTE, ESC_COMMAND);
        send_item(OP_BYTE, 8'h03);
        repeat (5) send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, ESC_COMMAND);
        send_item(OP_BYTE, 8'h04);
        repeat (2) send_item(OP_TICK, 8'h00);

        // The new idle code leaves the last key alone, so the same key is still a repeat.
        reconfigure(16'd40, 16'd2000, 9'd4, 8'h5A);
        send_item(OP_KEY, 8'h5A);
        send_item(OP_KEY, 8'h00);

        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: reconfigure(16'd0, 16'd0, 9'd0, 8'hFF);
                1: reconfigure(16'd3, 16'd10, 9'd256, 8'h00);
                2: reconfigure(16'hFFFF, 16'hFFFF, 9'd511, 8'h5A);
                3: reconfigure(16'd40, 16'd2000, 9'd4, 8'h00);
                4: reconfigure(16'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
                               9'($urandom_range(0, 12)), 8'($urandom_range(0, 255)));
                5: reconfigure(16'd1, 16'hFFFF, 9'd256, 8'hFF);
                6: reconfigure(16'hFFFF, 16'd0, 9'd255, 8'h01);
                default: begin
                    reconfigure(16'd2, 16'd6, 9'd8, 8'($urandom_range(0, 255)));
                    idle_on = 1'b0;
                end
            endcase
            if (ph == 1) long_hold_req = 1'b1;
            random_items(240);
        end

        wait_drained(10);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
